[sv/shfi_pkg.sv]
// shfi_pkg: shared constants for the symbol hash find-or-insert engine.
// Used by the top level, its RAM instance parameters and the port checker.
package shfi_pkg;

  // Default table shape
  localparam int SLOTS_DEF       = 128;
  localparam int NAME_GROUPS_DEF = 4;

  // Name groups and home-slot sum
  localparam int GROUP_W   = 16;
  localparam int MAX_GROUP = 4;
  localparam int SUM_W     = GROUP_W + 2;          // sum of up to four groups

  // Stream widths
  localparam int IN_TDATA_W  = 64;                 // name_key
  localparam int SLOT_OUT_W  = 7;                  // slot_index
  localparam int OUT_TDATA_W = 8;                  // slot_index, zero filled
  localparam int OUT_TUSER_W = 2;                  // found, overflow

  // Bit positions in out_tuser
  localparam int TUSER_FOUND = 0;
  localparam int TUSER_OVF   = 1;

endpackage

[sv/shfi_ram.sv]
// shfi_ram: generic single write port, single read port RAM, registered read.
// Standalone; no package dependency.
module shfi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/symbol_hash_find_or_insert.sv]
// symbol_hash_find_or_insert: open-addressed symbol table, linear probing.
// Depends on shfi_pkg (constants) and shfi_ram (name store).
//
//  channel | ports            | tdata (low bit up)            | tuser (low bit up)
//  --------+------------------+-------------------------------+-------------------
//  in      | in_tvalid/tready | name_key[63:0]                | -
//  out     | out_tvalid/tready| slot_index[6:0], 1'b0         | found, overflow
//
// After reset the name store is cleared, one slot a cycle, with in_tready
// low. Then one item at a time: in_tready is high only when idle.
// An item goes through hash, then probe (RAM read) and check (compare, in the
// 64-bit key compare) for each probe, then done; a non power-of-two SLOTS
// adds a hash step for the remainder (reciprocal multiply, then multiply
// back and subtract, on one shared multiplier). in_tready returns together
// with out_tvalid as the result is loaded into the output register; a
// stalled out_tready holds the engine.
module symbol_hash_find_or_insert #(
  parameter int SLOTS       = shfi_pkg::SLOTS_DEF,
  parameter int NAME_GROUPS = shfi_pkg::NAME_GROUPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [shfi_pkg::IN_TDATA_W-1:0] in_tdata,    // name_key[63:0]
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [shfi_pkg::OUT_TDATA_W-1:0] out_tdata,  // slot_index[6:0], pad
  output logic [shfi_pkg::OUT_TUSER_W-1:0] out_tuser   // found, overflow
);

  localparam int  SW         = $clog2(SLOTS);
  localparam int  KEY_W      = shfi_pkg::GROUP_W * NAME_GROUPS;
  localparam bit  SLOTS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  // Quotient = (sum * RECIP) >> RECIP_SH, exact for every sum below 2**SUM_W
  localparam int     RECIP_SH = shfi_pkg::SUM_W + SW;
  localparam int     RECIP_W  = shfi_pkg::SUM_W + 1;
  localparam int     PROD_W   = RECIP_SH + shfi_pkg::SUM_W;
  localparam longint RECIP    = ((longint'(1) << RECIP_SH) / SLOTS) + 1;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HASH  = 6'b000100,
    ST_PROBE = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [SW-1:0]                   slot_r, slot_nxt;        // also clear address
  logic [SW-1:0]                   probe_cnt_r, probe_cnt_nxt;
  logic [shfi_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [shfi_pkg::SUM_W-1:0]      quo_r, quo_nxt;
  logic                            quo_ok_r, quo_ok_nxt;    // quotient held
  logic [KEY_W-1:0]                key_r, key_nxt;
  logic                            found_r, found_nxt;
  logic                            ovf_r, ovf_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [shfi_pkg::SLOT_OUT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                              out_found_r, out_found_nxt;
  logic                              out_ovf_r, out_ovf_nxt;

  logic [shfi_pkg::SUM_W-1:0] in_sum;
  logic [shfi_pkg::SUM_W-1:0] mul_a;
  logic [RECIP_W-1:0]         mul_b;
  logic [PROD_W-1:0]          mul_prod;
  logic [shfi_pkg::SUM_W-1:0] home_rem;
  logic [SW-1:0]              slot_inc;
  logic                       cur_empty, cur_hit;

  logic             ram_wr_en;
  logic [KEY_W-1:0] ram_wr_data;
  logic [KEY_W-1:0] ram_rd_data;

  // Home-slot sum of the name groups, taken straight from the input
  always_comb begin
    in_sum = '0;
    for (int g = 0; g < NAME_GROUPS; g++) begin
      in_sum = in_sum + shfi_pkg::SUM_W'(in_tdata[g*shfi_pkg::GROUP_W +: shfi_pkg::GROUP_W]);
    end
  end

  // Shared multiplier: sum * RECIP first, then quotient * SLOTS
  assign mul_a    = quo_ok_r ? quo_r : sum_r;
  assign mul_b    = quo_ok_r ? RECIP_W'(SLOTS) : RECIP_M;
  assign mul_prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign home_rem = sum_r - mul_prod[shfi_pkg::SUM_W-1:0];

  assign slot_inc  = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
  assign cur_empty = (ram_rd_data == '0);
  assign cur_hit   = (ram_rd_data == key_r);

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    probe_cnt_nxt = probe_cnt_r;
    sum_nxt       = sum_r;
    quo_nxt       = quo_r;
    quo_ok_nxt    = quo_ok_r;
    key_nxt       = key_r;
    found_nxt     = found_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_slot_nxt  = out_slot_r;
    out_found_nxt = out_found_r;
    out_ovf_nxt   = out_ovf_r;
    ram_wr_en     = 1'b0;
    ram_wr_data   = key_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = '0;
        if (slot_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end else begin
          slot_nxt = slot_inc;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          key_nxt    = in_tdata[KEY_W-1:0];
          sum_nxt    = in_sum;
          quo_ok_nxt = 1'b0;
          state_nxt  = ST_HASH;
        end
      end
      ST_HASH: begin
        probe_cnt_nxt = '0;
        if (SLOTS_POW2) begin
          slot_nxt  = sum_r[SW-1:0];
          state_nxt = ST_PROBE;
        end else if (!quo_ok_r) begin
          quo_nxt    = mul_prod[RECIP_SH +: shfi_pkg::SUM_W];
          quo_ok_nxt = 1'b1;
        end else begin
          slot_nxt  = home_rem[SW-1:0];
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_nxt = ST_CHECK;                 // RAM read in flight
      end
      ST_CHECK: begin
        found_nxt = 1'b0;
        ovf_nxt   = 1'b0;
        if (cur_empty) begin
          ram_wr_en = (key_r != '0);          // zero name is never stored
          state_nxt = ST_DONE;
        end else if (cur_hit) begin
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (probe_cnt_r == LAST_SLOT) begin
          ovf_nxt   = 1'b1;                   // walked the whole table
          state_nxt = ST_DONE;
        end else begin
          slot_nxt      = slot_inc;
          probe_cnt_nxt = probe_cnt_r + 1'b1;
          state_nxt     = ST_PROBE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = ovf_r ? '0 : shfi_pkg::SLOT_OUT_W'(slot_r);
          out_found_nxt = found_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_cnt_r <= probe_cnt_nxt;
    sum_r       <= sum_nxt;
    quo_r       <= quo_nxt;
    quo_ok_r    <= quo_ok_nxt;
    key_r       <= key_nxt;
    found_r     <= found_nxt;
    ovf_r       <= ovf_nxt;
    out_slot_r  <= out_slot_nxt;
    out_found_r <= out_found_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // Name store: read address is always the current probe slot
  shfi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_names (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot_r),
    .wr_data (ram_wr_data),
    .rd_addr (slot_r),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = shfi_pkg::OUT_TDATA_W'(out_slot_r);
  assign out_tuser  = {out_ovf_r, out_found_r};

endmodule

[sv/shfi_chk.sv]
// shfi_chk: port-level checks for symbol_hash_find_or_insert, and its bind.
// Depends on shfi_pkg for port widths.
module shfi_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [shfi_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [shfi_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [shfi_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // found and overflow never together
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[shfi_pkg::TUSER_FOUND] && out_tuser[shfi_pkg::TUSER_OVF]))
    else $error("found and overflow both set");

  // overflow reports slot zero
  a_ovf_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[shfi_pkg::TUSER_OVF]) |-> (out_tdata == '0))
    else $error("overflow with non-zero slot");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready straight after accept");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("result changed while stalled");

endmodule

bind symbol_hash_find_or_insert shfi_chk u_shfi_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[dv/testbench.sv]
// testbench: self-checking bench for symbol_hash_find_or_insert (find-or-insert symbol table).
// Depends on shfi_pkg and the RTL; keeps its own copy of the table to predict each result.
// Directed rows first, then random lookups that load the table, fill it and run it full.
module testbench;

  localparam int SLOTS       = shfi_pkg::SLOTS_DEF;
  localparam int NAME_GROUPS = shfi_pkg::NAME_GROUPS_DEF;
  localparam int GROUP_W     = shfi_pkg::GROUP_W;
  localparam int MAX_GROUP   = shfi_pkg::MAX_GROUP;
  localparam int IN_TDATA_W  = shfi_pkg::IN_TDATA_W;
  localparam int SLOT_OUT_W  = shfi_pkg::SLOT_OUT_W;
  localparam int OUT_TDATA_W = shfi_pkg::OUT_TDATA_W;
  localparam int OUT_TUSER_W = shfi_pkg::OUT_TUSER_W;
  localparam int TUSER_FOUND = shfi_pkg::TUSER_FOUND;
  localparam int TUSER_OVF   = shfi_pkg::TUSER_OVF;
  localparam int RANDOM_LOAD = 200;  // lookups while the table fills up
  localparam int RANDOM_FULL = 220;  // lookups once every slot is taken

  // One lookup result as the block reports it
  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  found;
    logic                  overflow;
  } lookup_t;

  // Directed row: a name, and a typed-in answer where it is obvious
  typedef struct packed {
    logic [IN_TDATA_W-1:0] key;
    logic                  typed;
    lookup_t               want;
  } row_t;

  // Names are read low group first: 64'hGGGG_GGGG_GGGG_GGGG, group 0 at the right.
  // Home slot = sum of the four groups mod 128.
  localparam row_t DIRECTED [20] = '{
    // empty table: the zero name lands on its home slot 0 and is not stored
    '{64'h0000_0000_0000_0000, 1'b1, '{7'd0,   1'b0, 1'b0}},
    // all ones: sum 3FFFC, home 124
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{7'd124, 1'b0, 1'b0}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{7'd124, 1'b1, 1'b0}},
    '{64'h0000_0000_0000_0001, 1'b1, '{7'd1,   1'b0, 1'b0}},
    // same home slot 1 from other groups: a probe chain 1, 2, 3
    '{64'h0001_0000_0000_0000, 1'b0, '0},
    '{64'h0000_0000_0001_0000, 1'b0, '0},
    '{64'h0001_0000_0000_0000, 1'b0, '0},
    // zero name again: slot 0 still empty
    '{64'h0000_0000_0000_0000, 1'b1, '{7'd0,   1'b0, 1'b0}},
    // home 127 chain, wraps round to slot 0 and on into the slot-1 chain
    '{64'h0000_0000_0000_007F, 1'b0, '0},
    '{64'h0000_0000_007F_0000, 1'b0, '0},
    '{64'h0000_007F_0000_0000, 1'b0, '0},
    '{64'h007F_0000_0000_0000, 1'b0, '0},
    // zero name with home 0 now occupied: first empty slot past the chain
    '{64'h0000_0000_0000_0000, 1'b0, '0},
    '{64'h8000_8000_8000_8000, 1'b0, '0},
    '{64'hAAAA_5555_AAAA_5555, 1'b0, '0},
    '{64'h5555_AAAA_5555_AAAA, 1'b0, '0},
    '{64'h0000_0000_0000_FFFF, 1'b0, '0},
    '{64'hFFFF_0000_0000_0000, 1'b0, '0},
    '{64'h0000_0000_0000_007F, 1'b0, '0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{7'd124, 1'b1, 1'b0}}
  };

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // Shadow of the name store
  bit [IN_TDATA_W-1:0] held_names [SLOTS];
  int                  names_held = 0;
  logic [IN_TDATA_W-1:0] known_names [$];   // every name stored so far

  lookup_t pending_results [$];
  lookup_t due;
  int      errors     = 0;
  int      feed_calm  = 0;
  int      drain_calm = 0;
  int      drain_stall = 0;

  always #5 clk = ~clk;

  symbol_hash_find_or_insert uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Groups beyond NAME_GROUPS are neither hashed nor stored
  function automatic logic [IN_TDATA_W-1:0] visible_name(input logic [IN_TDATA_W-1:0] raw);
    logic [IN_TDATA_W-1:0] keep;
    keep = '0;
    for (int g = 0; g < NAME_GROUPS && g < MAX_GROUP; g++)
      keep[GROUP_W*g +: GROUP_W] = '1;
    return raw & keep;
  endfunction

  function automatic int home_of(input logic [IN_TDATA_W-1:0] key);
    int sum;
    sum = 0;
    for (int g = 0; g < MAX_GROUP; g++)
      sum += key[GROUP_W*g +: GROUP_W];
    return sum % SLOTS;
  endfunction

  // Linear probe from the home slot; store on the first empty slot unless the name is zero
  function automatic lookup_t find_or_insert(input logic [IN_TDATA_W-1:0] raw);
    logic [IN_TDATA_W-1:0] key;
    int                    probe;
    lookup_t               res;
    key   = visible_name(raw);
    probe = home_of(key);
    res   = '{slot: '0, found: 1'b0, overflow: 1'b1};  // table full, name absent
    for (int n = 0; n < SLOTS; n++) begin
      if (held_names[probe] == '0) begin
        if (key != '0) begin
          held_names[probe] = key;
          names_held++;
          known_names.push_back(key);
        end
        res = '{slot: probe[SLOT_OUT_W-1:0], found: 1'b0, overflow: 1'b0};
        return res;
      end
      if (held_names[probe] == key) begin
        res = '{slot: probe[SLOT_OUT_W-1:0], found: 1'b1, overflow: 1'b0};
        return res;
      end
      probe = (probe + 1) % SLOTS;
    end
    return res;
  endfunction

  // Mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 2);
    if (r < 92) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IN_TDATA_W-1:0] fresh_name();
    return {$urandom, $urandom};
  endfunction

  // Random name forced onto a given home slot: build clusters and wrap-round chains
  function automatic logic [IN_TDATA_W-1:0] name_homed_at(input int target);
    logic [IN_TDATA_W-1:0] key;
    int                    rest;
    key  = fresh_name();
    rest = key[31:16] + key[47:32] + key[63:48];
    key[15:0] = {9'($urandom_range(0, 511)), 7'((target - rest) % SLOTS + SLOTS)};
    return key;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] sparse_name();
    logic [IN_TDATA_W-1:0] key;
    key = '0;
    if ($urandom_range(0, 1)) key[$urandom_range(0, 63)] = 1'b1;
    else key[GROUP_W*$urandom_range(0, MAX_GROUP-1) +: GROUP_W] = GROUP_W'($urandom);
    return key;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] name_held_before();
    if (known_names.size() == 0) return fresh_name();
    return known_names[$urandom_range(0, known_names.size() - 1)];
  endfunction

  // Present one name, wait for the accept edge, then log what should come back
  task automatic offer_name(input logic [IN_TDATA_W-1:0] key, input logic typed,
                            input lookup_t want);
    int      gap;
    lookup_t predicted;
    if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
    gap = (feed_calm || $urandom_range(0, 1)) ? 0 : pause_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = find_or_insert(key);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Result side: check each accepted item, then pick out_tready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t result: expected none, got slot %0d found %0b overflow %0b", $time,
                 out_tdata, out_tuser[TUSER_FOUND], out_tuser[TUSER_OVF]);
        errors++;
      end else begin
        due = pending_results.pop_front();
        // slot_index sits in the low bits, the pad bit above must read zero
        if (out_tdata !== OUT_TDATA_W'(due.slot)) begin
          $display("%0t slot_index: expected %0d, got %0d", $time, due.slot, out_tdata);
          errors++;
        end
        if (out_tuser[TUSER_FOUND] !== due.found) begin
          $display("%0t found: expected %0b, got %0b", $time, due.found,
                   out_tuser[TUSER_FOUND]);
          errors++;
        end
        if (out_tuser[TUSER_OVF] !== due.overflow) begin
          $display("%0t overflow: expected %0b, got %0b", $time, due.overflow,
                   out_tuser[TUSER_OVF]);
          errors++;
        end
      end
    end
    if ($urandom_range(0, 199) == 0) drain_calm = !drain_calm;
    if (drain_stall > 0) begin
      out_tready <= 1'b0;
      drain_stall--;
    end else if (!drain_calm && $urandom_range(0, 99) < 30) begin
      out_tready  <= 1'b0;
      drain_stall = pause_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    int r;
    for (int s = 0; s < SLOTS; s++) held_names[s] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // in_tready stays low through the clearing pass; the handshake wait covers it

    foreach (DIRECTED[i])
      offer_name(DIRECTED[i].key, DIRECTED[i].typed, DIRECTED[i].want);

    // Load phase: new names, clustered homes around the wrap point, sparse names, hits, zero names
    for (int i = 0; i < RANDOM_LOAD; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      offer_name(fresh_name(), 1'b0, '0);
      else if (r < 45) offer_name(name_homed_at((SLOTS - 4 + $urandom_range(0, 7)) % SLOTS),
                                  1'b0, '0);
      else if (r < 55) offer_name(sparse_name(), 1'b0, '0);
      else if (r < 62) offer_name('0, 1'b0, '0);
      else             offer_name(name_held_before(), 1'b0, '0);
    end

    // Top the table up until no slot is empty
    while (names_held < SLOTS)
      offer_name($urandom_range(0, 1) ? fresh_name() : name_homed_at($urandom_range(0, SLOTS-1)),
                 1'b0, '0);

    // Full table: hits must still be found, everything else overflows
    for (int i = 0; i < RANDOM_FULL; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35)      offer_name(name_held_before(), 1'b0, '0);
      else if (r < 70) offer_name(fresh_name(), 1'b0, '0);
      else if (r < 80) offer_name('0, 1'b0, '0);
      else if (r < 90) offer_name(name_homed_at($urandom_range(0, SLOTS-1)), 1'b0, '0);
      else             offer_name(sparse_name(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (full-table probes, long stalls)
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
